// ----- rtl/core/dqt_pkg.sv -----
//------------------------------------------------------------------------------
// Delimiter and quote tokenizer package
// Shared types and constants for the tokenizer block.
//------------------------------------------------------------------------------
package dqt_pkg;

	localparam int DefPositionBits = 16;
	localparam int FieldBits       = 16;
	localparam int QueueDepth      = 4;

	localparam logic [63:0] MaskLowReset  = 64'hFC00_FF7A_0000_0000;
	localparam logic [63:0] MaskHighReset = 64'h6800_0001_7800_0001;

	typedef enum logic [1:0] {
		CFG_MASK_LOW  = 2'd0,
		CFG_MASK_HIGH = 2'd1,
		CFG_KEEP      = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		K_WORD  = 3'd0,
		K_DELIM = 3'd1,
		K_OPEN  = 3'd2,
		K_LIT   = 3'd3,
		K_CLOSE = 3'd4,
		K_SPAN  = 3'd5
	} token_kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_WORD  = 2'd1,
		MODE_QUOTE = 2'd2
	} scan_mode_t;

	typedef enum logic [1:0] {
		LB_NONE = 2'd0,
		LB_CR   = 2'd1,
		LB_LF   = 2'd2
	} line_break_t;

	localparam logic [7:0] ChSlash  = 8'h2F;
	localparam logic [7:0] ChSingle = 8'h27;
	localparam logic [7:0] ChDouble = 8'h22;
	localparam logic [7:0] ChCr     = 8'h0D;
	localparam logic [7:0] ChLf     = 8'h0A;
	localparam logic [7:0] ChSpace  = 8'h20;
	localparam logic [7:0] ChTab    = 8'h09;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  token_kind;
		logic [15:0] start_offset;
		logic [15:0] end_offset;
		logic [15:0] start_line;
		logic [15:0] start_column;
		logic        last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [1:0] cfg_index;
		logic [63:0] cfg_data;
	} cfg_item_t;

	typedef struct packed {
		logic         valid;
		token_kind_t  kind;
		logic [15:0]  s;
		logic [15:0]  e;
		logic [15:0]  line;
		logic [15:0]  col;
	} slot_t;

	typedef struct packed {
		slot_t [2:0] slot;
	} event_t;

endpackage

// ----- rtl/core/dqt_front.sv -----
//------------------------------------------------------------------------------
// Tokenizer front end
// Classifies each byte, tracks position and scan state, builds token events.
//------------------------------------------------------------------------------
module dqt_front
	import dqt_pkg::*;
#(
	parameter int PositionBits = DefPositionBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  in_item_t    item,
	input  logic        take,
	input  logic [63:0] mask_low_q,
	input  logic [63:0] mask_high_q,
	input  logic        keep_q,
	output event_t      ev
);

	localparam logic [PositionBits-1:0] Cap = '1;

	logic [PositionBits-1:0] pos_q, line_q, col_q, ts_off_q, ts_line_q, ts_col_q;
	scan_mode_t  mode_q, mode_n;
	logic        quote_q, quote_n, slash_q, slash_n;
	line_break_t lb_q, lb_n;
	logic [PositionBits-1:0] pos_n, line_n, col_n, tso_n, tsl_n, tsc_n;

	function automatic logic [PositionBits-1:0] sinc(logic [PositionBits-1:0] v);
		return (v == Cap) ? v : v + 1'b1;
	endfunction

	function automatic logic [15:0] f16(logic [PositionBits-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic slot_t mk(token_kind_t k, logic [PositionBits-1:0] s,
		logic [PositionBits-1:0] e, logic [PositionBits-1:0] l,
		logic [PositionBits-1:0] c);
		slot_t r;
		r.valid = 1'b1;
		r.kind  = k;
		r.s     = f16(s);
		r.e     = f16(e);
		r.line  = f16(l);
		r.col   = f16(c);
		return r;
	endfunction

	logic [7:0] b;
	logic       fin, sp, dl, qt, mbit, handled;
	logic [PositionBits-1:0] pm1;
	slot_t [2:0] sl;
	logic [1:0]  n;

	assign b   = item.text_byte;
	assign fin = item.final_byte;
	assign pm1 = (pos_q != '0) ? pos_q - 1'b1 : '0;

	always_comb begin
		mbit = b[6] ? mask_high_q[b[5:0]] : mask_low_q[b[5:0]];
		sp   = (b == ChSpace) || (b >= ChTab && b <= ChCr);
		dl   = !sp && !b[7] && mbit;
		qt   = !sp && !dl && (b == ChSingle || b == ChDouble);
	end

	always_comb begin
		sl      = '0;
		n       = 2'd0;
		handled = 1'b0;
		mode_n  = mode_q;
		quote_n = quote_q;
		slash_n = slash_q;
		tso_n   = ts_off_q;
		tsl_n   = ts_line_q;
		tsc_n   = ts_col_q;
		if (slash_q) begin
			slash_n = 1'b0;
			if (b == ChSlash) begin
				sl[n] = mk(K_DELIM, ts_off_q, pos_q, ts_line_q, ts_col_q);
				handled = 1'b1;
			end else begin
				sl[n] = mk(K_DELIM, ts_off_q, ts_off_q, ts_line_q, ts_col_q);
			end
			n = n + 2'd1;
		end
		if (!handled) begin
			if (mode_q == MODE_QUOTE) begin
				if (b == (quote_q ? ChSingle : ChDouble)) begin
					if (keep_q) begin
						sl[n] = mk(K_LIT, sinc(ts_off_q), pm1, ts_line_q, sinc(ts_col_q));
						n = n + 2'd1;
						sl[n] = mk(K_CLOSE, pos_q, pos_q, line_q, col_q);
						n = n + 2'd1;
					end else begin
						sl[n] = mk(K_SPAN, ts_off_q, pos_q, ts_line_q, ts_col_q);
						n = n + 2'd1;
					end
					mode_n = MODE_IDLE;
				end
			end else begin
				if (mode_q == MODE_WORD && (sp || dl || qt)) begin
					sl[n] = mk(K_WORD, ts_off_q, pm1, ts_line_q, ts_col_q);
					n = n + 2'd1;
					mode_n = MODE_IDLE;
				end
				if (mode_n != MODE_WORD) begin
					mode_n = MODE_IDLE;
					if (sp) begin
						mode_n = MODE_IDLE;
					end else if (dl) begin
						if (keep_q) begin
							if (b == ChSlash) begin
								slash_n = 1'b1;
								tso_n = pos_q;
								tsl_n = line_q;
								tsc_n = col_q;
							end else begin
								sl[n] = mk(K_DELIM, pos_q, pos_q, line_q, col_q);
								n = n + 2'd1;
							end
						end
					end else if (qt) begin
						tso_n = pos_q;
						tsl_n = line_q;
						tsc_n = col_q;
						quote_n = (b == ChSingle);
						mode_n = MODE_QUOTE;
						if (keep_q) begin
							sl[n] = mk(K_OPEN, pos_q, pos_q, line_q, col_q);
							n = n + 2'd1;
						end
					end else begin
						tso_n = pos_q;
						tsl_n = line_q;
						tsc_n = col_q;
						mode_n = MODE_WORD;
					end
				end
			end
		end
		if (fin) begin
			if (mode_n == MODE_WORD) begin
				sl[n] = mk(K_WORD, tso_n, pos_q, tsl_n, tsc_n);
				n = n + 2'd1;
			end else if (mode_n == MODE_QUOTE) begin
				if (keep_q) begin
					if (pos_q > tso_n) begin
						sl[n] = mk(K_LIT, sinc(tso_n), pos_q, tsl_n, sinc(tsc_n));
						n = n + 2'd1;
					end
				end else begin
					sl[n] = mk(K_SPAN, tso_n, pos_q, tsl_n, tsc_n);
					n = n + 2'd1;
				end
			end
			if (slash_n) begin
				sl[n] = mk(K_DELIM, tso_n, tso_n, tsl_n, tsc_n);
			end
		end
	end

	always_comb begin
		pos_n  = sinc(pos_q);
		line_n = line_q;
		col_n  = col_q;
		lb_n   = lb_q;
		if (b == ChCr || b == ChLf) begin
			if (lb_q != LB_NONE && lb_q != ((b == ChCr) ? LB_CR : LB_LF)) begin
				lb_n = LB_NONE;
			end else begin
				line_n = sinc(line_q);
				col_n  = PositionBits'(1);
				lb_n   = (b == ChCr) ? LB_CR : LB_LF;
			end
		end else begin
			col_n = sinc(col_q);
			lb_n  = LB_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			line_q    <= PositionBits'(1);
			col_q     <= PositionBits'(1);
			ts_off_q  <= '0;
			ts_line_q <= PositionBits'(1);
			ts_col_q  <= PositionBits'(1);
			mode_q    <= MODE_IDLE;
			quote_q   <= 1'b0;
			slash_q   <= 1'b0;
			lb_q      <= LB_NONE;
		end else if (take) begin
			if (fin) begin
				pos_q     <= '0;
				line_q    <= PositionBits'(1);
				col_q     <= PositionBits'(1);
				ts_off_q  <= '0;
				ts_line_q <= PositionBits'(1);
				ts_col_q  <= PositionBits'(1);
				mode_q    <= MODE_IDLE;
				quote_q   <= 1'b0;
				slash_q   <= 1'b0;
				lb_q      <= LB_NONE;
			end else begin
				pos_q     <= pos_n;
				line_q    <= line_n;
				col_q     <= col_n;
				ts_off_q  <= tso_n;
				ts_line_q <= tsl_n;
				ts_col_q  <= tsc_n;
				mode_q    <= mode_n;
				quote_q   <= quote_n;
				slash_q   <= slash_n;
				lb_q      <= lb_n;
			end
		end
	end

	assign ev.slot = sl;

endmodule

// ----- rtl/core/dqt_back.sv -----
//------------------------------------------------------------------------------
// Tokenizer back end
// Queues token events and emits their tokens one transaction at a time.
//------------------------------------------------------------------------------
module dqt_back
	import dqt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  event_t    ev,
	input  logic      push,
	output logic      space,
	output out_item_t out_item,
	output logic      out_valid,
	input  logic      out_ready
);

	localparam int Aw = $clog2(QueueDepth);

	event_t          mem [QueueDepth];
	logic [Aw-1:0]   wp_q, rp_q;
	logic [Aw:0]     cnt_q;
	logic [1:0]      idx_q;
	logic            pop_ev, empty_ev;
	event_t          head;
	logic [2:0]      later;

	assign head     = mem[rp_q];
	assign space    = (cnt_q < (Aw+1)'(QueueDepth - 1));
	always_comb begin
		later[0] = head.slot[1].valid || head.slot[2].valid;
		later[1] = head.slot[2].valid;
		later[2] = 1'b0;
	end
	assign out_valid = (cnt_q != '0) && head.slot[idx_q].valid;
	assign pop_ev    = (cnt_q != '0) && (!head.slot[idx_q].valid ||
		(out_ready && !later[idx_q]));
	assign empty_ev  = !(ev.slot[0].valid);

	always_comb begin
		out_item.token_kind   = head.slot[idx_q].kind;
		out_item.start_offset = head.slot[idx_q].s;
		out_item.end_offset   = head.slot[idx_q].e;
		out_item.start_line   = head.slot[idx_q].line;
		out_item.start_column = head.slot[idx_q].col;
		out_item.last_of_run  = !later[idx_q];
	end

	always_ff @(posedge clk) begin
		if (push && !empty_ev) begin
			mem[wp_q] <= ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (push && !empty_ev) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop_ev) begin
				rp_q  <= rp_q + 1'b1;
				idx_q <= '0;
			end else if (out_valid && out_ready) begin
				idx_q <= idx_q + 2'd1;
			end
			cnt_q <= cnt_q + (Aw+1)'(push && !empty_ev) - (Aw+1)'(pop_ev);
		end
	end

endmodule

// ----- rtl/core/delimiter_quote_tokenizer_unit.sv -----
//------------------------------------------------------------------------------
// Delimiter and quote tokenizer
// Splits a byte stream into word, delimiter and quote tokens with positions.
//------------------------------------------------------------------------------
// Text enters on the in channel one byte per transaction, with final_byte on
// the last byte of a text. Tokens leave on the out channel, one per
// transaction; last_of_run marks the final token caused by one byte.
// Registers must be written on the cfg channel only while the block is idle;
// the block does not enforce this. The front end classifies a byte in the
// cycle it is accepted and places up to three tokens into a four-entry
// event queue, which registers them. The back end drains one token per cycle
// while the receiver is ready. One byte is accepted per cycle while the queue
// has room; a byte that causes two or three tokens holds the back end until
// all of them have left. When the receiver stalls, the queue fills and
// in_ready drops after three pending events. Reset clears the text position,
// scan state and the queue and loads the default delimiter mask and keep mode.
//------------------------------------------------------------------------------
module delimiter_quote_tokenizer_unit
	import dqt_pkg::*;
#(
	parameter int PositionBits = DefPositionBits
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	input  logic      in_valid,
	output logic      in_ready,
	output out_item_t out_data,
	output logic      out_valid,
	input  logic      out_ready,
	input  cfg_item_t cfg_data,
	input  logic      cfg_valid,
	output logic      cfg_ready
);

	logic [63:0] mask_low_q, mask_high_q;
	logic        keep_q, take, space;
	event_t      ev;

	assign cfg_ready = 1'b1;
	assign in_ready  = space;
	assign take      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_low_q  <= MaskLowReset;
			mask_high_q <= MaskHighReset;
			keep_q      <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_data.cfg_index))
				CFG_MASK_LOW:  mask_low_q  <= cfg_data.cfg_data;
				CFG_MASK_HIGH: mask_high_q <= cfg_data.cfg_data;
				CFG_KEEP:      keep_q      <= cfg_data.cfg_data[0];
				default:       keep_q      <= keep_q;
			endcase
		end
	end

	dqt_front #(.PositionBits(PositionBits)) u_front (
		.clk, .arst_n, .item(in_data), .take,
		.mask_low_q, .mask_high_q, .keep_q, .ev
	);

	dqt_back u_back (
		.clk, .arst_n, .ev, .push(take), .space,
		.out_item(out_data), .out_valid, .out_ready
	);

	a_out_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.token_kind <= K_SPAN) else $error("bad token kind");
	a_out_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.start_line != 16'd0) else $error("zero line");
	a_out_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.start_column != 16'd0) else $error("zero column");

endmodule

// ----- bench/token_checker.sv -----
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Tokenizer transaction checker
// Watches the text, token and register channels of the tokenizer, predicts the
// tokens of every accepted byte and compares them with the tokens that leave.
//------------------------------------------------------------------------------
module token_checker
	import dqt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	input  logic      in_valid,
	input  logic      in_ready,
	input  out_item_t out_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  cfg_item_t cfg_data,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	output int        errors,
	output int        pending
);

	localparam logic [15:0] PosCap = 16'hFFFF;

	logic [63:0] mask_lo, mask_hi;
	logic        keep;
	logic [15:0] pos_q, line_q, col_q, tok_off, tok_line, tok_col;
	scan_mode_t  mode;
	logic        quote_single, slash_wait;
	line_break_t lb_state;
	out_item_t   tokens_due[$];
	out_item_t   run[$];
	int          fails = 0;

	assign errors = fails;

	function automatic logic [15:0] bump(logic [15:0] v);
		return (v == PosCap) ? v : v + 16'd1;
	endfunction

	function automatic logic [15:0] prev(logic [15:0] v);
		return (v == 16'd0) ? v : v - 16'd1;
	endfunction

	task automatic emit(token_kind_t k, logic [15:0] s, logic [15:0] e,
		logic [15:0] l, logic [15:0] c);
		out_item_t t;
		t.token_kind   = k;
		t.start_offset = s;
		t.end_offset   = e;
		t.start_line   = l;
		t.start_column = c;
		t.last_of_run  = 1'b0;
		run.insert(run.size(), t);
	endtask

	task automatic clear_text();
		pos_q = '0; line_q = 16'd1; col_q = 16'd1;
		tok_off = '0; tok_line = 16'd1; tok_col = 16'd1;
		mode = MODE_IDLE; quote_single = 1'b0; slash_wait = 1'b0; lb_state = LB_NONE;
	endtask

	task automatic tokenize(logic [7:0] b, logic fin);
		logic [15:0] p, l, c;
		logic handled, sp, dl, qt;
		logic [7:0] qc;
		line_break_t kind;
		p = pos_q; l = line_q; c = col_q;
		handled = 1'b0;
		run.delete();
		if (slash_wait) begin
			slash_wait = 1'b0;
			if (b == ChSlash) begin
				emit(K_DELIM, tok_off, p, tok_line, tok_col);
				handled = 1'b1;
			end else begin
				emit(K_DELIM, tok_off, tok_off, tok_line, tok_col);
			end
		end
		if (!handled) begin
			if (mode == MODE_QUOTE) begin
				qc = quote_single ? ChSingle : ChDouble;
				if (b == qc) begin
					if (keep) begin
						emit(K_LIT, bump(tok_off), prev(p), tok_line, bump(tok_col));
						emit(K_CLOSE, p, p, l, c);
					end else begin
						emit(K_SPAN, tok_off, p, tok_line, tok_col);
					end
					mode = MODE_IDLE;
				end
			end else begin
				sp = (b == ChSpace) || (b >= ChTab && b <= ChCr);
				dl = !sp && !b[7] && (b[6] ? mask_hi[b[5:0]] : mask_lo[b[5:0]]);
				qt = !sp && !dl && (b == ChSingle || b == ChDouble);
				if (mode == MODE_WORD && (sp || dl || qt)) begin
					emit(K_WORD, tok_off, prev(p), tok_line, tok_col);
					mode = MODE_IDLE;
				end
				if (mode != MODE_WORD) begin
					if (sp) begin
					end else if (dl) begin
						if (keep) begin
							if (b == ChSlash) begin
								slash_wait = 1'b1;
								tok_off = p; tok_line = l; tok_col = c;
							end else begin
								emit(K_DELIM, p, p, l, c);
							end
						end
					end else if (qt) begin
						tok_off = p; tok_line = l; tok_col = c;
						quote_single = (b == ChSingle);
						mode = MODE_QUOTE;
						if (keep)
							emit(K_OPEN, p, p, l, c);
					end else begin
						tok_off = p; tok_line = l; tok_col = c;
						mode = MODE_WORD;
					end
				end
			end
		end
		if (fin) begin
			if (mode == MODE_WORD) begin
				emit(K_WORD, tok_off, p, tok_line, tok_col);
			end else if (mode == MODE_QUOTE) begin
				if (keep) begin
					if (p > tok_off)
						emit(K_LIT, bump(tok_off), p, tok_line, bump(tok_col));
				end else begin
					emit(K_SPAN, tok_off, p, tok_line, tok_col);
				end
			end
			if (slash_wait)
				emit(K_DELIM, tok_off, tok_off, tok_line, tok_col);
			clear_text();
		end else begin
			pos_q = bump(p);
			if (b == ChCr || b == ChLf) begin
				kind = (b == ChCr) ? LB_CR : LB_LF;
				if (lb_state != LB_NONE && lb_state != kind) begin
					lb_state = LB_NONE;
				end else begin
					line_q = bump(l);
					col_q = 16'd1;
					lb_state = kind;
				end
			end else begin
				col_q = bump(c);
				lb_state = LB_NONE;
			end
		end
		if (run.size() > 0)
			run[run.size() - 1].last_of_run = 1'b1;
		foreach (run[i])
			tokens_due.insert(tokens_due.size(), run[i]);
	endtask

	task automatic compare(out_item_t got);
		out_item_t want;
		if (tokens_due.size() == 0) begin
			$error("unexpected token transaction kind %0d start %0d",
				got.token_kind, got.start_offset);
			fails++;
			return;
		end
		want = tokens_due.pop_front();
		if (got.token_kind !== want.token_kind) begin
			$error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
			fails++;
		end
		if (got.start_offset !== want.start_offset) begin
			$error("start_offset: expected %0d, got %0d", want.start_offset,
				got.start_offset);
			fails++;
		end
		if (got.end_offset !== want.end_offset) begin
			$error("end_offset: expected %0d, got %0d", want.end_offset, got.end_offset);
			fails++;
		end
		if (got.start_line !== want.start_line) begin
			$error("start_line: expected %0d, got %0d", want.start_line, got.start_line);
			fails++;
		end
		if (got.start_column !== want.start_column) begin
			$error("start_column: expected %0d, got %0d", want.start_column,
				got.start_column);
			fails++;
		end
		if (got.last_of_run !== want.last_of_run) begin
			$error("last_of_run: expected %0d, got %0d", want.last_of_run,
				got.last_of_run);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_lo = MaskLowReset;
			mask_hi = MaskHighReset;
			keep = 1'b1;
			clear_text();
			tokens_due.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready)
				compare(out_data);
			if (in_valid && in_ready)
				tokenize(in_data.text_byte, in_data.final_byte);
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.cfg_index)
					CFG_MASK_LOW:  mask_lo = cfg_data.cfg_data;
					CFG_MASK_HIGH: mask_hi = cfg_data.cfg_data;
					CFG_KEEP:      keep = cfg_data.cfg_data[0];
					default: ;
				endcase
			end
			pending = tokens_due.size();
		end
	end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Tokenizer testbench
// Feeds directed and random texts under several delimiter masks and keep
// modes, with random stalls on both channels, and reports the verdict.
//------------------------------------------------------------------------------
module testbench;
	import dqt_pkg::*;

	localparam int CycleLimit = 400000;

	logic      clk = 0;
	logic      arst_n = 0;
	in_item_t  in_data = '0;
	logic      in_valid = 0;
	logic      in_ready;
	out_item_t out_data;
	logic      out_valid;
	logic      out_ready = 0;
	cfg_item_t cfg_data = '0;
	logic      cfg_valid = 0;
	logic      cfg_ready;
	int        errors, pending;
	int        cycles = 0;
	int        send_idle = 0, recv_idle = 0;

	delimiter_quote_tokenizer_unit uut (.*);
	token_checker checker_i (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		out_ready <= ($urandom_range(99) >= recv_idle);
		if (cycles > CycleLimit) begin
			$display("** delimiter_quote_tokenizer_unit: FAILED **");
			$finish;
		end
	end

	task automatic send_byte(logic [7:0] b, logic fin);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data <= '{text_byte: b, final_byte: fin};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [63:0] v);
		drain();
		cfg_data <= '{cfg_index: idx, cfg_data: v};
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(99);
		if (r < 40) return 8'h61 + 8'($urandom_range(25));
		if (r < 52) return ChSpace;
		if (r < 60) return ($urandom_range(1) != 0) ? ChCr : ChLf;
		if (r < 68) return ChSlash;
		if (r < 76) return ($urandom_range(1) != 0) ? ChSingle : ChDouble;
		if (r < 88) return 8'h21 + 8'($urandom_range(14));
		return 8'($urandom_range(255));
	endfunction

	task automatic random_texts(int count);
		int left;
		left = count;
		while (left > 0) begin
			int n;
			n = $urandom_range(1, 14);
			if (n > left) n = left;
			for (int i = 0; i < n; i++)
				send_byte(pick_byte(), i == n - 1);
			left -= n;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 7; recv_idle = 48;
		send_text("ab,c//d/e\"x y\"'q'\"\"\377");
		send_text("w'ab");
		send_text("\r\n\n\r\r\rz\t'");
		send_text("/");
		write_reg(CFG_KEEP, 64'd0);
		send_text("k(\"lit, x\"m\"open");
		send_text("'");
		send_byte(ChSlash, 1'b0);
		write_reg(CFG_KEEP, 64'd1);
		send_text("x");
		random_texts(60);
		drain();
		write_reg(CFG_MASK_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(CFG_MASK_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
		send_idle = 48; recv_idle = 7;
		random_texts(40);
		write_reg(CFG_MASK_LOW, 64'd0);
		write_reg(CFG_MASK_HIGH, 64'd0);
		write_reg(CFG_KEEP, 64'd0);
		random_texts(40);
		write_reg(CFG_MASK_LOW, {$urandom, $urandom});
		write_reg(CFG_MASK_HIGH, {$urandom, $urandom});
		send_idle = 0; recv_idle = 0;
		random_texts(30);
		write_reg(CFG_KEEP, 64'd1);
		write_reg(CFG_MASK_LOW, MaskLowReset);
		write_reg(CFG_MASK_HIGH, MaskHighReset);
		random_texts(40);
		drain();
		if (errors == 0)
			$display("** delimiter_quote_tokenizer_unit: PASSED **");
		else
			$display("** delimiter_quote_tokenizer_unit: FAILED **");
		$finish;
	end

endmodule
